[rtl/som_pkg.sv]
// ----------------------------------------------------------------------------
// som_pkg
// Shared types and constants of the self-organizing map training engine.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int N_NEURONS = 16;
  localparam int DIM         = 4;
  localparam int MAX_K       = 8;
  localparam int SAMPLE_W    = 16;

  localparam int NIDX_W  = $clog2(N_NEURONS);
  localparam int NCNT_W  = NIDX_W + 1;
  localparam int COMP_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KIDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KCNT_W  = $clog2(MAX_K + 1);
  localparam int WADDR_W = NIDX_W + COMP_W;
  localparam int TADDR_W = NIDX_W + KIDX_W;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int MUL_W   = 2 * DIFF_W;
  localparam int ACC_W   = 2 * SAMPLE_W + 1 + COMP_W;
  localparam int RATE_W  = 16;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 16;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_REFRESH  = 2'd3
  } op_e;

  localparam logic [CIDX_W-1:0] REG_LEARNING_RATE = 8'd0;
  localparam logic [CIDX_W-1:0] REG_INFLUENCE     = 8'd1;
  localparam logic [CIDX_W-1:0] REG_NEIGHBOR_K    = 8'd2;
  localparam logic [CIDX_W-1:0] REG_NEURONS_USED  = 8'd3;

  typedef struct packed {
    op_e                         opcode;
    logic [3:0]                  neuron_index;
    logic                        with_neighbors;
    logic signed [SAMPLE_W-1:0]  sample_c0;
    logic signed [SAMPLE_W-1:0]  sample_c1;
    logic signed [SAMPLE_W-1:0]  sample_c2;
    logic signed [SAMPLE_W-1:0]  sample_c3;
  } in_word_t;

  typedef struct packed {
    logic [3:0] winner;
    logic       winner_valid;
  } out_word_t;

endpackage

[rtl/som_ram.sv]
// ----------------------------------------------------------------------------
// som_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module som_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/som_train_engine.sv]
// ----------------------------------------------------------------------------
// som_train_engine
// Self-organizing map engine: weight load, classify, train, neighbor refresh.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 word
// in       input      in_valid_i / in_ready_o    in_word_i  (in_word_t)
// out      output     out_valid_o / out_ready_i  out_word_o (out_word_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word at a time; one multiplier does every product, one component a step.
// Every op is accepted in ST_IDLE and returns its result from ST_FIN. Load:
// writes each component. Classify: nearest active neuron. Train: classify, move
// the winner and, with neighbors, its list. Refresh: rebuild each k-nearest list.
// Reset empties all neighbor lists at once. A result not yet taken holds the
// engine in its result cycle until out_ready_i.
module som_train_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  som_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output som_pkg::out_word_t          out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [som_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [som_pkg::CDATA_W-1:0] cfg_data_i
);
  import som_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DA, ST_DB, ST_DM, ST_DC, ST_DEND,
    ST_MRD, ST_MMUL, ST_MWR, ST_RATE, ST_NRD, ST_NGET,
    ST_RINIT, ST_RWR, ST_FIN
  } state_e;

  state_e state_q;

  logic [RATE_W-1:0] lr_q, infl_q, rate_q, nrate_q;
  logic [3:0]        cfg_k_q;
  logic [4:0]        cfg_n_q;

  op_e                        op_q;
  logic [NIDX_W-1:0]          nidx_q;
  logic                       with_nb_q;
  logic signed [SAMPLE_W-1:0] samp_q [DIM];

  logic [NCNT_W-1:0]          i_q, j_q;
  logic [COMP_W-1:0]          d_q;
  logic [KCNT_W-1:0]          m_q;
  logic [ACC_W-1:0]           acc_q, best_d_q;
  logic [NIDX_W-1:0]          best_q, move_idx_q;
  logic                       nb_phase_q;
  logic signed [SAMPLE_W-1:0] opa_q, w_q;
  logic signed [MUL_W-1:0]    prod_q;

  logic [ACC_W-1:0]  ld_q [MAX_K];
  logic [NIDX_W-1:0] li_q [MAX_K];
  logic [KCNT_W-1:0] lcnt_q;
  logic [KCNT_W-1:0] fill_q [N_NEURONS];

  out_word_t out_q;
  logic      out_valid_q;

  // RAM ports
  logic                w_we;
  logic [WADDR_W-1:0]  w_waddr, w_raddr;
  logic [SAMPLE_W-1:0] w_wdata, w_rdata;
  logic                t_we;
  logic [TADDR_W-1:0]  t_waddr, t_raddr;
  logic [NIDX_W-1:0]   t_rdata;

  som_ram #(.WIDTH(SAMPLE_W), .DEPTH(N_NEURONS * DIM)) u_weights (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  som_ram #(.WIDTH(NIDX_W), .DEPTH(N_NEURONS * MAX_K)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(li_q[m_q[KIDX_W-1:0]]),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  // active count and list length
  logic [NCNT_W-1:0] n_act;
  logic [NCNT_W-1:0] k_eff;
  logic [NCNT_W-1:0] k_cap;
  always_comb begin
    if (cfg_n_q < 5'd2) n_act = NCNT_W'(2);
    else if (cfg_n_q > 5'(N_NEURONS)) n_act = NCNT_W'(N_NEURONS);
    else n_act = NCNT_W'(cfg_n_q);
    k_cap = (cfg_k_q > 4'(MAX_K)) ? NCNT_W'(MAX_K) : NCNT_W'(cfg_k_q);
    k_eff = (k_cap > n_act - NCNT_W'(1)) ? n_act - NCNT_W'(1) : k_cap;
  end

  // shared multiplier
  logic signed [DIFF_W-1:0] diff_ab, diff_xw, mul_a, mul_b;
  logic signed [MUL_W-1:0]  mul_p;
  assign diff_ab = DIFF_W'(opa_q) - DIFF_W'($signed(w_rdata));
  assign diff_xw = DIFF_W'(samp_q[d_q]) - DIFF_W'($signed(w_rdata));
  always_comb begin
    case (state_q)
      ST_DM: begin
        mul_a = diff_ab;
        mul_b = diff_ab;
      end
      ST_RATE: begin
        mul_a = $signed({1'b0, infl_q});
        mul_b = $signed({1'b0, lr_q});
      end
      default: begin
        mul_a = $signed({1'b0, rate_q});
        mul_b = diff_xw;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // step and saturate
  localparam int SUM_W = DIFF_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (SAMPLE_W - 1)));
  logic signed [SUM_W-1:0]    step_sum;
  logic signed [SAMPLE_W-1:0] nw;
  assign step_sum = SUM_W'(w_q) + SUM_W'($signed(prod_q[MUL_W-1:16]));
  always_comb begin
    if (step_sum > SUM_MAX)
      nw = {1'b0, {(SAMPLE_W-1){1'b1}}};
    else if (step_sum < SUM_MIN)
      nw = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else
      nw = step_sum[SAMPLE_W-1:0];
  end

  // sorted insertion
  logic [MAX_K-1:0] lt;
  always_comb begin
    for (int p = 0; p < MAX_K; p++) begin
      lt[p] = (KCNT_W'(p) >= lcnt_q) || (acc_q < ld_q[p]);
    end
  end

  logic [NCNT_W-1:0] j_next;
  always_comb begin
    j_next = j_q + NCNT_W'(1);
    if (op_q == OP_REFRESH && j_next == i_q) j_next = j_q + NCNT_W'(2);
  end

  logic is_last_d;
  assign is_last_d = (d_q == COMP_W'(DIM - 1));

  always_comb begin
    w_raddr = {j_q[NIDX_W-1:0], d_q};
    case (state_q)
      ST_DA:   w_raddr = {i_q[NIDX_W-1:0], d_q};
      ST_MRD:  w_raddr = {move_idx_q, d_q};
      default: w_raddr = {j_q[NIDX_W-1:0], d_q};
    endcase
    w_we    = (state_q == ST_LOAD) || (state_q == ST_MWR);
    w_waddr = (state_q == ST_LOAD) ? {nidx_q, d_q} : {move_idx_q, d_q};
    w_wdata = (state_q == ST_LOAD) ? samp_q[d_q] : nw;
    t_we    = (state_q == ST_RWR);
    t_waddr = {i_q[NIDX_W-1:0], m_q[KIDX_W-1:0]};
    t_raddr = {best_q, m_q[KIDX_W-1:0]};
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lr_q        <= 16'd19661;
      infl_q      <= 16'd6554;
      cfg_k_q     <= 4'd4;
      cfg_n_q     <= 5'd10;
      for (int q = 0; q < N_NEURONS; q++) fill_q[q] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LEARNING_RATE: lr_q    <= cfg_data_i;
          REG_INFLUENCE:     infl_q  <= cfg_data_i;
          REG_NEIGHBOR_K:    cfg_k_q <= cfg_data_i[3:0];
          REG_NEURONS_USED:  cfg_n_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != ST_FIN) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q      <= in_word_i.opcode;
            nidx_q    <= in_word_i.neuron_index;
            with_nb_q <= in_word_i.with_neighbors;
            samp_q[0] <= in_word_i.sample_c0;
            samp_q[1] <= in_word_i.sample_c1;
            samp_q[2] <= in_word_i.sample_c2;
            samp_q[3] <= in_word_i.sample_c3;
            d_q       <= '0;
            j_q       <= '0;
            i_q       <= '0;
            acc_q     <= '0;
            case (in_word_i.opcode)
              OP_LOAD:    state_q <= ST_LOAD;
              OP_REFRESH: begin
                for (int q = 0; q < N_NEURONS; q++) fill_q[q] <= '0;
                state_q <= ST_RINIT;
              end
              default:    state_q <= ST_DB;
            endcase
          end
        end
        ST_LOAD: begin
          d_q <= d_q + COMP_W'(1);
          if (is_last_d) state_q <= ST_FIN;
        end
        ST_DA: state_q <= ST_DB;
        ST_DB: begin
          opa_q   <= (op_q == OP_REFRESH) ? $signed(w_rdata) : samp_q[d_q];
          state_q <= ST_DM;
        end
        ST_DM: begin
          prod_q  <= mul_p;
          state_q <= ST_DC;
        end
        ST_DC: begin
          acc_q <= acc_q + ACC_W'(prod_q[MUL_W-2:0]);
          d_q   <= d_q + COMP_W'(1);
          if (is_last_d) state_q <= ST_DEND;
          else state_q <= (op_q == OP_REFRESH) ? ST_DA : ST_DB;
        end
        ST_DEND: begin
          acc_q <= '0;
          d_q   <= '0;
          j_q   <= j_next;
          if (op_q == OP_REFRESH) begin
            for (int p = 0; p < MAX_K; p++) begin
              if (p == 0 ? lt[0] : (lt[p] && !lt[p > 0 ? p-1 : 0])) begin
                ld_q[p] <= acc_q;
                li_q[p] <= j_q[NIDX_W-1:0];
              end else if (p > 0 && lt[p > 0 ? p-1 : 0]) begin
                ld_q[p] <= ld_q[p > 0 ? p-1 : 0];
                li_q[p] <= li_q[p > 0 ? p-1 : 0];
              end
            end
            if (lcnt_q != KCNT_W'(MAX_K)) lcnt_q <= lcnt_q + KCNT_W'(1);
            if (j_next >= n_act) begin
              m_q <= '0;
              if (k_eff == '0) begin
                i_q     <= i_q + NCNT_W'(1);
                state_q <= (i_q + NCNT_W'(1) == n_act) ? ST_FIN : ST_RINIT;
              end else begin
                state_q <= ST_RWR;
              end
            end else begin
              state_q <= ST_DA;
            end
          end else begin
            if (j_q == '0 || acc_q < best_d_q) begin
              best_d_q <= acc_q;
              best_q   <= j_q[NIDX_W-1:0];
            end
            if (j_next >= n_act) begin
              move_idx_q <= (j_q == '0 || acc_q < best_d_q) ? j_q[NIDX_W-1:0] : best_q;
              rate_q     <= lr_q;
              nb_phase_q <= 1'b0;
              state_q    <= (op_q == OP_TRAIN) ? ST_MRD : ST_FIN;
            end else begin
              state_q <= ST_DB;
            end
          end
        end
        ST_MRD: state_q <= ST_MMUL;
        ST_MMUL: begin
          prod_q  <= mul_p;
          w_q     <= $signed(w_rdata);
          state_q <= ST_MWR;
        end
        ST_MWR: begin
          d_q <= d_q + COMP_W'(1);
          if (!is_last_d) begin
            state_q <= ST_MRD;
          end else if (!nb_phase_q) begin
            state_q <= with_nb_q ? ST_RATE : ST_FIN;
          end else begin
            m_q     <= m_q + KCNT_W'(1);
            state_q <= (m_q + KCNT_W'(1) == fill_q[best_q]) ? ST_FIN : ST_NRD;
          end
        end
        ST_RATE: begin
          nrate_q <= mul_p[31:16];
          m_q     <= '0;
          state_q <= (fill_q[best_q] == '0) ? ST_FIN : ST_NRD;
        end
        ST_NRD: state_q <= ST_NGET;
        ST_NGET: begin
          move_idx_q <= t_rdata;
          rate_q     <= nrate_q;
          nb_phase_q <= 1'b1;
          d_q        <= '0;
          state_q    <= ST_MRD;
        end
        ST_RINIT: begin
          lcnt_q  <= '0;
          j_q     <= (i_q == '0) ? NCNT_W'(1) : '0;
          d_q     <= '0;
          acc_q   <= '0;
          state_q <= ST_DA;
        end
        ST_RWR: begin
          m_q <= m_q + KCNT_W'(1);
          if (NCNT_W'(m_q) + NCNT_W'(1) == k_eff) begin
            fill_q[i_q[NIDX_W-1:0]] <= KCNT_W'(k_eff);
            i_q     <= i_q + NCNT_W'(1);
            state_q <= (i_q + NCNT_W'(1) == n_act) ? ST_FIN : ST_RINIT;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q        <= 1'b1;
            out_q.winner       <= (op_q == OP_TRAIN || op_q == OP_CLASSIFY) ? best_q : '0;
            out_q.winner_valid <= (op_q == OP_TRAIN || op_q == OP_CLASSIFY);
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
